[hw/rtl/ahfe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahfe_pkg
// Shared constants and types of the ASCII header frame extractor: character
// codes, header positions, field widths and the result item layout.
// ----------------------------------------------------------------------------
package ahfe_pkg;

    // Default sizing
    localparam int BUFFER_BYTES_DEF    = 16384;
    localparam int MAX_FIELD_CHARS_DEF = 10;
    localparam int SHIFT_BYTES_DEF     = 6;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int TYPE_W     = 31;
    localparam int LEN_OUT_W  = 15;
    localparam int FC_W       = 4;   // holds up to MAX_FIELD_CHARS + 1
    localparam int ACC_EXT_W  = 35;  // acc * 10 + digit before saturation
    localparam int LEN_SUM_W  = 33;  // byte count + decoded length
    localparam int TDATA_W    = 56;
    localparam int TUSER_W    = 2;

    localparam logic [TYPE_W-1:0]    NUM_SAT      = '1;
    localparam logic [TYPE_W-1:0]    TYPE_SHIFTED = TYPE_W'(1000);

    // Character codes
    localparam logic [BYTE_W-1:0] CHR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHR_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CHR_B      = 8'h42;
    localparam logic [BYTE_W-1:0] CHR_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CHR_O      = 8'h4F;
    localparam logic [BYTE_W-1:0] CHR_V      = 8'h56;
    localparam logic [BYTE_W-1:0] CHR_E      = 8'h45;
    localparam logic [BYTE_W-1:0] CHR_F      = 8'h46;
    localparam logic [BYTE_W-1:0] CHR_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CHR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CHR_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CHR_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CHR_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CHR_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CHR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_NINE   = 8'h39;

    // Header byte positions (byte count after the byte is taken)
    localparam int HDR_POS_G    = 2;
    localparam int HDR_POS_B    = 3;
    localparam int HDR_POS_R    = 4;
    localparam int HDR_POS_KIND = 5;

    // Comma numbers that close the type and length fields
    localparam logic [1:0] COMMA_TYPE = 2'd2;
    localparam logic [1:0] COMMA_LEN  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0]    out_byte;
        logic                 byte_valid;
        logic                 is_reference;
        logic [TYPE_W-1:0]    msg_type;
        logic [LEN_OUT_W-1:0] payload_length;
        logic                 last;
    } result_t;

endpackage
`default_nettype wire

[hw/rtl/ascii_header_frame_extractor_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_header_frame_extractor_unit
// Results are registered: into the result register, or into the skid entry on a stall.
// Throughput: one input item per cycle, with no gaps while m_tready stays high.
// A skid entry behind the result register lets s_tready depend on registers only;
// s_tready is low after a stalled cycle fills it, until it moves up.
// Reset (aresetn low, synchronous): parser idle, counters, delay line and output valid cleared.
// ----------------------------------------------------------------------------
// Frames "$GBROV,type,len," / "$GBREF,type,len," headers and streams len
// payload bytes out, tagged with type, rover/reference flag and length.
// Rover frames of the shifted type deliver bytes from SHIFT_BYTES earlier.
// ----------------------------------------------------------------------------
module ascii_header_frame_extractor_unit
    import ahfe_pkg::*;
#(
    parameter int BUFFER_BYTES    = BUFFER_BYTES_DEF,
    parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF,
    parameter int SHIFT_BYTES     = SHIFT_BYTES_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    // input stream
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [BYTE_W-1:0]   s_tdata,   // [7:0] in_byte
    // result stream
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [38:8] msg_type,
                                           // [53:39] payload_length, [55:54] zero
    output logic [TUSER_W-1:0]  m_tuser,   // [0] byte_valid, [1] is_reference
    output logic                m_tlast    // last
);

    localparam int CW       = $clog2(BUFFER_BYTES + 1);
    localparam int DL_DEPTH = (SHIFT_BYTES > 0) ? SHIFT_BYTES : 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_SKIP,
        PH_FIELDS,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    typedef enum logic [1:0] {
        NUM_LEAD,
        NUM_DIGITS,
        NUM_DONE
    } num_stage_t;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    phase_t              phase_reg,       phase_next;
    logic [CW-1:0]       byte_count_reg,  byte_count_next;
    logic                hdr_match_reg,   hdr_match_next;
    logic                ref_flag_reg,    ref_flag_next;
    logic [1:0]          comma_cnt_reg,   comma_cnt_next;
    logic [FC_W-1:0]     field_chars_reg, field_chars_next;
    logic [TYPE_W-1:0]   type_reg,        type_next;
    logic [LEN_OUT_W-1:0] length_reg,     length_next;
    logic [CW-1:0]       remaining_reg,   remaining_next;
    logic [TYPE_W-1:0]   acc_reg,         acc_next;
    logic                neg_reg,         neg_next;
    num_stage_t          stage_reg,       stage_next;
    logic                field_bad_reg,   field_bad_next;
    logic [BYTE_W-1:0]   dl_reg [DL_DEPTH];

    // Output entries
    logic                m_valid_reg;
    result_t             m_res_reg;
    logic                skid_valid_reg;
    result_t             skid_res_reg;

    // Per-item working signals
    logic                s_accept;
    logic [BYTE_W-1:0]   b;
    logic [BYTE_W-1:0]   delayed;
    logic                is_crlf;
    logic                is_ws;
    logic                is_sign;
    logic                is_digit;
    logic [ACC_EXT_W-1:0] acc_ext;
    logic [TYPE_W-1:0]   acc_digit;
    logic [FC_W-1:0]     fc_inc;
    logic [TYPE_W-1:0]   field_val;
    logic                field_long;
    logic                bad_now;
    logic [CW-1:0]       bc_eff;
    phase_t              ph_eff;
    logic [CW-1:0]       bc_inc;
    logic [LEN_SUM_W-1:0] frame_sum;
    logic                hdr_ok;
    logic [1:0]          cc_inc;
    logic [CW-1:0]       rem_dec;
    logic                res_valid;
    result_t             res;
    logic                out_free;

    assign s_tready = ~skid_valid_reg;
    assign s_accept = s_tvalid & s_tready;
    assign b        = s_tdata;

    // Byte from SHIFT_BYTES items ago; the live byte when no shift is set
    assign delayed  = (SHIFT_BYTES > 0) ? dl_reg[DL_DEPTH-1] : b;

    // Character classes
    assign is_crlf  = (b == CHR_CR) || (b == CHR_LF);
    assign is_ws    = (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
    assign is_sign  = (b == CHR_PLUS) || (b == CHR_MINUS);
    assign is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);

    // Decimal accumulate: acc * 10 + digit, saturating at 2^31-1
    assign acc_ext   = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {{(ACC_EXT_W-BYTE_W){1'b0}}, (b - CHR_ZERO)};
    assign acc_digit = (acc_ext > {{(ACC_EXT_W-TYPE_W){1'b0}}, NUM_SAT})
                     ? NUM_SAT : acc_ext[TYPE_W-1:0];
    assign fc_inc    = (field_chars_reg <= FC_W'(MAX_FIELD_CHARS))
                     ? field_chars_reg + FC_W'(1) : field_chars_reg;

    // Value of the field closed by a comma
    assign field_val  = neg_reg ? '0 : acc_reg;
    assign field_long = field_chars_reg > FC_W'(MAX_FIELD_CHARS);
    assign bad_now    = field_bad_reg | field_long;

    // Buffer limit: once BUFFER_BYTES taken since '$', treat the byte as idle
    assign ph_eff  = (byte_count_reg >= CW'(BUFFER_BYTES)) ? PH_IDLE : phase_reg;
    assign bc_eff  = (byte_count_reg >= CW'(BUFFER_BYTES)) ? '0 : byte_count_reg;
    assign bc_inc  = bc_eff + CW'(1);
    assign cc_inc  = comma_cnt_reg + 2'd1;
    assign rem_dec = (remaining_reg != '0) ? remaining_reg - CW'(1) : remaining_reg;
    assign frame_sum = LEN_SUM_W'(bc_inc) + LEN_SUM_W'(field_val);
    assign hdr_ok    = hdr_match_reg & (b == (ref_flag_reg ? CHR_F : CHR_V));

    // ------------------------------------------------------------------
    // Parser next state
    // ------------------------------------------------------------------
    always_comb begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        hdr_match_next   = hdr_match_reg;
        ref_flag_next    = ref_flag_reg;
        comma_cnt_next   = comma_cnt_reg;
        field_chars_next = field_chars_reg;
        type_next        = type_reg;
        length_next      = length_reg;
        remaining_next   = remaining_reg;
        acc_next         = acc_reg;
        neg_next         = neg_reg;
        stage_next       = stage_reg;
        field_bad_next   = field_bad_reg;
        res_valid        = 1'b0;
        res.out_byte     = '0;
        res.byte_valid   = 1'b0;
        res.last         = 1'b0;

        if (s_accept) begin
            phase_next      = ph_eff;
            byte_count_next = bc_inc;
            unique case (ph_eff)
                PH_IDLE: begin
                    byte_count_next = '0;
                    if (b == CHR_DOLLAR) begin
                        phase_next      = PH_HDR;
                        byte_count_next = CW'(1);
                        hdr_match_next  = 1'b1;
                        ref_flag_next   = 1'b0;
                    end
                end
                PH_HDR: begin
                    if (bc_inc == CW'(HDR_POS_G)) begin
                        if (b != CHR_G) hdr_match_next = 1'b0;
                    end else if (bc_inc == CW'(HDR_POS_B)) begin
                        if (b != CHR_B) hdr_match_next = 1'b0;
                    end else if (bc_inc == CW'(HDR_POS_R)) begin
                        if (b != CHR_R) hdr_match_next = 1'b0;
                    end else if (bc_inc == CW'(HDR_POS_KIND)) begin
                        if (b == CHR_E) ref_flag_next = 1'b1;
                        else if (b != CHR_O) hdr_match_next = 1'b0;
                    end else begin
                        hdr_match_next = hdr_ok;
                        if (hdr_ok) begin
                            phase_next       = PH_FIELDS;
                            comma_cnt_next   = '0;
                            field_bad_next   = 1'b0;
                            field_chars_next = '0;
                            acc_next         = '0;
                            neg_next         = 1'b0;
                            stage_next       = NUM_LEAD;
                        end else if (is_crlf) begin
                            phase_next      = PH_IDLE;
                            byte_count_next = '0;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (is_crlf) begin
                        phase_next      = PH_IDLE;
                        byte_count_next = '0;
                    end
                end
                PH_FIELDS: begin
                    if (b == CHR_COMMA) begin
                        comma_cnt_next = cc_inc;
                        if (cc_inc == COMMA_TYPE) begin
                            type_next      = field_val;
                            field_bad_next = bad_now;
                        end
                        if (cc_inc == COMMA_LEN) begin
                            length_next    = field_val[LEN_OUT_W-1:0];
                            field_bad_next = bad_now;
                            if (bad_now) begin
                                // drop the frame
                                phase_next      = PH_IDLE;
                                byte_count_next = '0;
                            end else if (frame_sum > LEN_SUM_W'(BUFFER_BYTES)) begin
                                phase_next = PH_DISCARD;
                            end else if (field_val == '0) begin
                                // empty frame: one end mark
                                res_valid       = 1'b1;
                                res.last        = 1'b1;
                                phase_next      = PH_IDLE;
                                byte_count_next = '0;
                            end else begin
                                remaining_next = field_val[CW-1:0];
                                phase_next     = PH_PAYLOAD;
                            end
                        end else begin
                            field_chars_next = '0;
                            acc_next         = '0;
                            neg_next         = 1'b0;
                            stage_next       = NUM_LEAD;
                        end
                    end else if (comma_cnt_reg != '0) begin
                        field_chars_next = fc_inc;
                        if (stage_reg == NUM_LEAD && is_ws) begin
                            // skip leading blanks
                        end else if (stage_reg == NUM_LEAD && is_sign) begin
                            neg_next   = (b == CHR_MINUS);
                            stage_next = NUM_DIGITS;
                        end else if (stage_reg != NUM_DONE) begin
                            if (is_digit) begin
                                acc_next   = acc_digit;
                                stage_next = NUM_DIGITS;
                            end else begin
                                stage_next = NUM_DONE;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    remaining_next = rem_dec;
                    res_valid      = 1'b1;
                    res.byte_valid = 1'b1;
                    res.out_byte   = (!ref_flag_reg && type_reg == TYPE_SHIFTED) ? delayed : b;
                    res.last       = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        phase_next      = PH_IDLE;
                        byte_count_next = '0;
                    end
                end
                default: begin
                    // discard: count bytes until the buffer limit
                end
            endcase
        end

        res.is_reference   = ref_flag_next;
        res.msg_type       = type_next;
        res.payload_length = length_next;
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            byte_count_reg  <= '0;
            hdr_match_reg   <= 1'b0;
            ref_flag_reg    <= 1'b0;
            comma_cnt_reg   <= '0;
            field_chars_reg <= '0;
            type_reg        <= '0;
            length_reg      <= '0;
            remaining_reg   <= '0;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            stage_reg       <= NUM_LEAD;
            field_bad_reg   <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            hdr_match_reg   <= hdr_match_next;
            ref_flag_reg    <= ref_flag_next;
            comma_cnt_reg   <= comma_cnt_next;
            field_chars_reg <= field_chars_next;
            type_reg        <= type_next;
            length_reg      <= length_next;
            remaining_reg   <= remaining_next;
            acc_reg         <= acc_next;
            neg_reg         <= neg_next;
            stage_reg       <= stage_next;
            field_bad_reg   <= field_bad_next;
        end
    end

    // Delay line: advance on every accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DL_DEPTH; i++) dl_reg[i] <= '0;
        end else if (s_accept) begin
            dl_reg[0] <= b;
            for (int i = 1; i < DL_DEPTH; i++) dl_reg[i] <= dl_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    assign out_free = ~m_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                // drain the skid entry first; input is held meanwhile
                m_valid_reg    <= 1'b1;
                m_res_reg      <= skid_res_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= res_valid;
                m_res_reg   <= res;
            end
        end else if (res_valid) begin
            // result register stalled: park the new item
            skid_valid_reg <= 1'b1;
            skid_res_reg   <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_res_reg.payload_length, m_res_reg.msg_type,
                       m_res_reg.out_byte};
    assign m_tuser  = {m_res_reg.is_reference, m_res_reg.byte_valid};
    assign m_tlast  = m_res_reg.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held while result register empty");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_res_reg.byte_valid) |-> m_res_reg.last)
        else $error("empty frame result without last mark");

    a_payload_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (remaining_reg != '0))
        else $error("payload phase with no bytes remaining");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= CW'(BUFFER_BYTES))
        else $error("byte count beyond buffer size");

endmodule
`default_nettype wire

[verif/ascii_header_frame_extractor_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_header_frame_extractor_unit_test
// Self-checking bench for the ASCII header frame extractor. A queue-fed driver
// streams bytes in, a behavioural copy of the framer predicts every result
// item, and a monitor compares each item on the result stream with the oldest
// prediction. Runs directed frames, an oversized frame and random traffic
// under several flow-control regimes.
// ----------------------------------------------------------------------------
module ascii_header_frame_extractor_unit_test;
    import ahfe_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 380;   // per flow-control phase
    localparam int END_PAUSE      = 8;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_HEADER,
        PARSE_SKIP,
        PARSE_DECIMALS,
        PARSE_PAYLOAD,
        PARSE_DISCARD
    } parse_phase_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [TUSER_W-1:0]   m_tuser;
    logic                 m_tlast;

    ascii_header_frame_extractor_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0] byte_queue [$];     // items waiting for the driver
    result_t           payload_expect [$]; // predicted result items, oldest first
    int unsigned       bytes_queued   = 0;
    int unsigned       bytes_accepted = 0;
    int unsigned       mismatches     = 0;
    int unsigned       quiet_cycles   = 0;
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    bit                in_taken       = 1'b0;

    // ------------------------------------------------------------------------
    // Framer state as the block should hold it
    // ------------------------------------------------------------------------
    parse_phase_t      rx_phase   = PARSE_IDLE;
    int unsigned       rx_count   = 0;     // bytes taken since '$'
    bit                hdr_ok     = 1'b0;
    bit                frame_ref  = 1'b0;
    int unsigned       comma_seen = 0;
    int unsigned       fld_chars  = 0;
    bit                fld_long   = 1'b0;
    logic [TYPE_W-1:0] frame_type = '0;
    logic [31:0]       frame_len  = '0;
    int unsigned       bytes_left = 0;
    logic [31:0]       num_acc    = '0;
    bit                num_neg    = 1'b0;
    int unsigned       num_stage  = 0;     // 0 blanks/sign, 1 digits, 2 done
    logic [BYTE_W-1:0] recent [SHIFT_BYTES_DEF] = '{default: '0};  // [0] newest

    function automatic void open_field();
        fld_chars = 0;
        num_acc   = '0;
        num_neg   = 1'b0;
        num_stage = 0;
    endfunction

    // Close a decimal field: flag an overlong one, read a negative one as zero.
    function automatic logic [31:0] close_field();
        if (fld_chars > MAX_FIELD_CHARS_DEF) fld_long = 1'b1;
        return num_neg ? 32'd0 : num_acc;
    endfunction

    // Advance the framer by one input byte; return 1 when a result item is due.
    function automatic bit frame_byte(input logic [BYTE_W-1:0] rx, output result_t res);
        logic [BYTE_W-1:0] delayed;
        logic [31:0]       digit;
        logic [31:0]       closed;
        bit                blank;
        bit                sign;
        bit                emitted;
        int                i;
        emitted = 1'b0;
        res     = '0;
        delayed = recent[SHIFT_BYTES_DEF-1];
        for (i = SHIFT_BYTES_DEF - 1; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = rx;

        // Buffer full since '$': treat this byte as if idle
        if (rx_count >= BUFFER_BYTES_DEF) begin
            rx_phase = PARSE_IDLE;
            rx_count = 0;
        end

        case (rx_phase)
            PARSE_IDLE: begin
                rx_count = 0;
                if (rx == CHR_DOLLAR) begin
                    rx_phase  = PARSE_HEADER;
                    rx_count  = 1;
                    hdr_ok    = 1'b1;
                    frame_ref = 1'b0;
                end
            end
            PARSE_HEADER: begin
                rx_count++;
                if (rx_count == HDR_POS_G) begin
                    if (rx != CHR_G) hdr_ok = 1'b0;
                end else if (rx_count == HDR_POS_B) begin
                    if (rx != CHR_B) hdr_ok = 1'b0;
                end else if (rx_count == HDR_POS_R) begin
                    if (rx != CHR_R) hdr_ok = 1'b0;
                end else if (rx_count == HDR_POS_KIND) begin
                    if (rx == CHR_E) frame_ref = 1'b1;
                    else if (rx != CHR_O) hdr_ok = 1'b0;
                end else begin
                    if (rx != (frame_ref ? CHR_F : CHR_V)) hdr_ok = 1'b0;
                    if (hdr_ok) begin
                        rx_phase   = PARSE_DECIMALS;
                        comma_seen = 0;
                        fld_long   = 1'b0;
                        open_field();
                    end else if (rx == CHR_CR || rx == CHR_LF) begin
                        rx_phase = PARSE_IDLE;
                        rx_count = 0;
                    end else begin
                        rx_phase = PARSE_SKIP;
                    end
                end
            end
            PARSE_SKIP: begin
                rx_count++;
                if (rx == CHR_CR || rx == CHR_LF) begin
                    rx_phase = PARSE_IDLE;
                    rx_count = 0;
                end
            end
            PARSE_DECIMALS: begin
                rx_count++;
                if (rx == CHR_COMMA) begin
                    comma_seen++;
                    if (comma_seen == COMMA_TYPE) begin
                        closed     = close_field();
                        frame_type = closed[TYPE_W-1:0];
                    end
                    if (comma_seen == COMMA_LEN) begin
                        frame_len = close_field();
                        if (fld_long) begin
                            rx_phase = PARSE_IDLE;
                            rx_count = 0;
                        end else if (64'(rx_count) + 64'(frame_len) > BUFFER_BYTES_DEF) begin
                            rx_phase = PARSE_DISCARD;
                        end else if (frame_len == 0) begin
                            res.last = 1'b1;
                            emitted  = 1'b1;
                            rx_phase = PARSE_IDLE;
                            rx_count = 0;
                        end else begin
                            bytes_left = frame_len;
                            rx_phase   = PARSE_PAYLOAD;
                        end
                    end else begin
                        open_field();
                    end
                end else if (comma_seen != 0) begin
                    if (fld_chars <= MAX_FIELD_CHARS_DEF) fld_chars++;
                    blank = (rx == CHR_SPACE) || (rx >= CHR_TAB && rx <= CHR_CR);
                    sign  = (rx == CHR_PLUS) || (rx == CHR_MINUS);
                    if (num_stage == 0 && sign) begin
                        num_neg   = (rx == CHR_MINUS);
                        num_stage = 1;
                    end else if (!(num_stage == 0 && blank)) begin
                        if (num_stage == 0) num_stage = 1;
                        if (num_stage == 1) begin
                            if (rx >= CHR_ZERO && rx <= CHR_NINE) begin
                                digit = 32'(rx - CHR_ZERO);
                                if (num_acc > ({1'b0, NUM_SAT} - digit) / 10)
                                    num_acc = {1'b0, NUM_SAT};
                                else
                                    num_acc = num_acc * 10 + digit;
                            end else begin
                                num_stage = 2;
                            end
                        end
                    end
                end
            end
            PARSE_PAYLOAD: begin
                rx_count++;
                // rover frames of the shifted type deliver the older stream byte
                res.out_byte   = (!frame_ref && frame_type == TYPE_SHIFTED) ? delayed : rx;
                if (bytes_left > 0) bytes_left--;
                res.byte_valid = 1'b1;
                res.last       = (bytes_left == 0);
                emitted        = 1'b1;
                if (bytes_left == 0) begin
                    rx_phase = PARSE_IDLE;
                    rx_count = 0;
                end
            end
            default: begin
                rx_count++;
            end
        endcase

        if (emitted) begin
            res.is_reference   = frame_ref;
            res.msg_type       = frame_type;
            res.payload_length = frame_len[LEN_OUT_W-1:0];
        end
        return emitted;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        byte_queue.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_random_bytes(input int n);
        int i;
        for (i = 0; i < n; i++) push_byte(BYTE_W'($urandom_range(255)));
    endtask

    // Filler that holds a line, a field or a discard open: no line end, comma or '$'
    task automatic push_filler(input int n);
        logic [BYTE_W-1:0] b;
        int                i;
        for (i = 0; i < n; i++) begin
            b = BYTE_W'($urandom_range(255));
            if (b == CHR_CR || b == CHR_LF || b == CHR_COMMA || b == CHR_DOLLAR) b = CHR_G;
            push_byte(b);
        end
    endtask

    task automatic push_line_ends(input int n);
        int i;
        for (i = 0; i < n; i++) push_byte(CHR_LF);
    endtask

    task automatic push_frame(input bit is_ref, input string junk, input string type_txt,
                              input string len_txt, input int n_payload);
        push_text($sformatf("%s%s,%s,%s,", is_ref ? "$GBREF" : "$GBROV", junk,
                            type_txt, len_txt));
        push_random_bytes(n_payload);
    endtask

    function automatic string random_type_text();
        case ($urandom_range(9))
            0, 1, 2: return "1000";
            3:       return $sformatf("%0d", $urandom());        // may saturate
            4:       return $sformatf(" +%0d", $urandom_range(999));
            5:       return $sformatf("-%0d", $urandom_range(99));
            6:       return "";
            7:       return $sformatf("%0dx", $urandom_range(2000));
            default: return $sformatf("%0d", $urandom_range(4095));
        endcase
    endfunction

    // One random case: mostly well-formed frames, the rest noise and broken frames
    task automatic push_random_case();
        int    pick;
        int    len;
        string len_txt;
        pick = $urandom_range(99);
        if (pick < 75) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(13, 60) : $urandom_range(12);
            case ($urandom_range(5))
                0:       len_txt = $sformatf(" %0d", len);
                1:       len_txt = $sformatf("+%0d", len);
                2:       len_txt = $sformatf("0%0d", len);
                default: len_txt = $sformatf("%0d", len);
            endcase
            push_frame($urandom_range(1), ($urandom_range(9) == 0) ? "ab" : "",
                       random_type_text(), len_txt, len);
        end else if (pick < 85) begin
            push_random_bytes($urandom_range(1, 6));
            push_line_ends(6);
        end else if (pick < 93) begin
            push_text("$GBR");
            push_random_bytes(2 + $urandom_range(4));
            push_line_ends(6);
        end else begin
            if ($urandom_range(1))
                push_text("$GBROV,12345678901,3,");
            else
                push_text("$GBREF,1,   000000001,");
            push_random_bytes(3);
            push_line_ends(6);
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge. Hold an offered item until it
    // is taken, then offer the next one or idle at random. The result side
    // stalls at random too.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge. Check each result item
    // against the oldest prediction, then run the framer on any byte taken.
    // The watchdog trips when neither channel moves for too long.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        result_t due;
        bit      out_taken;
        if (!aresetn) begin
            in_taken = 1'b0;
        end else begin
            in_taken  = s_tvalid && s_tready;
            out_taken = m_tvalid && m_tready;

            if (out_taken) begin
                if (payload_expect.size() == 0) begin
                    $error("unexpected result item: tdata %h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    want = payload_expect.pop_front();
                    check_field("out_byte", want.out_byte, m_tdata[BYTE_W-1:0]);
                    check_field("msg_type", want.msg_type, m_tdata[BYTE_W +: TYPE_W]);
                    check_field("payload_length", want.payload_length,
                                m_tdata[BYTE_W+TYPE_W +: LEN_OUT_W]);
                    check_field("tdata_pad", 0,
                                m_tdata[TDATA_W-1:BYTE_W+TYPE_W+LEN_OUT_W]);
                    check_field("byte_valid", want.byte_valid, m_tuser[0]);
                    check_field("is_reference", want.is_reference, m_tuser[1]);
                    check_field("last", want.last, m_tlast);
                end
            end

            if (in_taken) begin
                bytes_accepted++;
                if (frame_byte(s_tdata, due)) payload_expect.push_back(due);
            end

            if (in_taken || out_taken) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("** ascii_header_frame_extractor_unit: FAILED **");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, then four flow-control phases of stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned base;
        int          phase_no;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        for (phase_no = 0; phase_no < 4; phase_no++) begin
            case (phase_no)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase

            if (phase_no == 0) begin
                // stray bytes and line ends while idle
                push_byte(8'h00);
                push_byte(8'hFF);
                push_byte(CHR_CR);
                push_byte(CHR_LF);
                push_byte(CHR_G);
                // plain rover and reference frames, payload extremes
                push_frame(1'b0, "", "5", "3", 3);
                push_text("$GBREF,77,2,");
                push_byte(8'h00);
                push_byte(8'hFF);
                // empty frame
                push_frame(1'b0, "", "9", "0", 0);
                // shifted rover type, and the same type on a reference frame
                push_frame(1'b0, "", "1000", "8", 8);
                push_frame(1'b1, "", "1000", "4", 4);
                // a wrong character at each header position: skip to line end
                push_text("$XBROV,1,1,");
                push_byte(CHR_CR);
                push_text("$GXROV,1,1,");
                push_byte(CHR_LF);
                push_text("$GBXOV,1,1,");
                push_byte(CHR_CR);
                push_text("$GBRXV,1,1,");
                push_byte(CHR_LF);
                push_text("$GBROF,1,1,");
                push_byte(CHR_CR);
                push_text("$GBREV,1,1,");
                push_byte(CHR_LF);
                // line ends inside the header, and a doubled '$'
                push_text("$GB");
                push_byte(CHR_CR);
                push_text("O");
                push_byte(CHR_LF);
                push_text("$$GBROV");
                push_byte(CHR_LF);
                // junk before the first comma, blanks, signs, trailing junk
                push_frame(1'b1, "xyz", "  +12x3", " 2", 2);
                push_frame(1'b0, "", "-5", "1", 1);
                // saturated type, then empty fields
                push_frame(1'b1, "", "9999999999", "1", 1);
                push_frame(1'b0, "", "", "", 0);
                // overlong type and length fields: frame dropped
                push_text("$GBROV,12345678901,1,A");
                push_text("$GBREF,3,00000000001,B");
            end

            base = bytes_queued;
            while (bytes_queued - base < RANDOM_BYTES) push_random_case();

            if (phase_no == 3) begin
                // frame one byte too big for the buffer: drop what follows
                push_frame(1'b0, "", "1", "16370", 0);
                push_filler(20);
            end

            while (byte_queue.size() != 0) @(posedge aclk);
        end

        // drain: every byte taken and every prediction met, then a short pause
        while (bytes_accepted != bytes_queued || payload_expect.size() != 0) @(negedge aclk);
        repeat (END_PAUSE) @(posedge aclk);

        if (mismatches == 0)
            $display("** ascii_header_frame_extractor_unit: PASSED **");
        else
            $display("** ascii_header_frame_extractor_unit: FAILED **");
        $finish;
    end

endmodule
